// ----- sv/rpb_pkg.sv -----
`default_nettype none

package rpb_pkg;

    // fixed field widths
    localparam int CFG_W      = 13;
    localparam int FUNC_W     = 3;
    localparam int CHAR_W     = 8;
    localparam int WORD_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int NCHARS     = 8;

    // defaults handed to the top level
    localparam int MAX_LIMIT_DEF = 4096;
    localparam int LIMIT_RESET   = 1024;
    localparam int QUEUE_DEPTH   = 4;

    // request function codes
    localparam logic [FUNC_W-1:0] FUNC_START    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_RAW      = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_WORD_MSB = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_WORD_SWP = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_HEX      = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_SUM      = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_FINISH   = 3'd6;

    // job kinds after decode
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_START = 3'd0;
    localparam t_kind KIND_RAW   = 3'd1;
    localparam t_kind KIND_WORD  = 3'd2;
    localparam t_kind KIND_HEX   = 3'd3;
    localparam t_kind KIND_SUM   = 3'd4;
    localparam t_kind KIND_NONE  = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MARKER = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CHAR_HASH   = 8'h23;
    localparam logic [3:0]        NIBBLE_MASK = 4'hF;

    typedef logic [NCHARS-1:0][CHAR_W-1:0] t_chars;

    typedef struct packed {
        t_kind  kind;
        t_chars chars;
    } t_job;

    function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] nib);
        logic [CHAR_W-1:0] ch;
        case (nib & NIBBLE_MASK)
            4'h0: ch = "0";
            4'h1: ch = "1";
            4'h2: ch = "2";
            4'h3: ch = "3";
            4'h4: ch = "4";
            4'h5: ch = "5";
            4'h6: ch = "6";
            4'h7: ch = "7";
            4'h8: ch = "8";
            4'h9: ch = "9";
            4'ha: ch = "a";
            4'hb: ch = "b";
            4'hc: ch = "c";
            4'hd: ch = "d";
            4'he: ch = "e";
            default: ch = "f";
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- sv/rpb_ifs.sv -----
`default_nettype none

interface rpb_req_if;
    logic                         valid;
    logic                         ready;
    logic [rpb_pkg::FUNC_W-1:0]   func;
    logic [rpb_pkg::CHAR_W-1:0]   data_byte;
    logic [rpb_pkg::WORD_W-1:0]   value_word;

    modport source (output valid, func, data_byte, value_word, input ready);
    modport sink   (input valid, func, data_byte, value_word, output ready);
endinterface

interface rpb_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [rpb_pkg::CHAR_W-1:0]   out_char;
    logic                         char_valid;
    logic                         run_last;
    logic [rpb_pkg::STATUS_W-1:0] status;

    modport source (output valid, out_char, char_valid, run_last, status, input ready);
    modport sink   (input valid, out_char, char_valid, run_last, status, output ready);
endinterface

interface rpb_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [rpb_pkg::CFG_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- sv/rpb_front.sv -----
`default_nettype none

// Decodes a request into a job: kind plus any state-independent characters.
module rpb_front (
    rpb_req_if.sink        i_req,
    output rpb_pkg::t_job  o_job,
    output logic           o_job_valid,
    input  wire logic      i_job_ready
);

    always_comb begin
        o_job       = '0;
        o_job_valid = i_req.valid;
        case (i_req.func)
            rpb_pkg::FUNC_START: begin
                o_job.kind = rpb_pkg::KIND_START;
            end
            rpb_pkg::FUNC_RAW: begin
                o_job.kind     = rpb_pkg::KIND_RAW;
                o_job.chars[0] = i_req.data_byte;
            end
            rpb_pkg::FUNC_WORD_MSB: begin
                o_job.kind = rpb_pkg::KIND_WORD;
                for (int j = 0; j < rpb_pkg::NCHARS; j++) begin
                    o_job.chars[j] = rpb_pkg::hex_digit(i_req.value_word[4*(7-j) +: 4]);
                end
            end
            rpb_pkg::FUNC_WORD_SWP: begin
                o_job.kind = rpb_pkg::KIND_WORD;
                // byte 0 first, high nibble first within each byte
                for (int b = 0; b < 4; b++) begin
                    o_job.chars[2*b]   = rpb_pkg::hex_digit(i_req.value_word[8*b+4 +: 4]);
                    o_job.chars[2*b+1] = rpb_pkg::hex_digit(i_req.value_word[8*b +: 4]);
                end
            end
            rpb_pkg::FUNC_HEX: begin
                o_job.kind     = rpb_pkg::KIND_HEX;
                o_job.chars[0] = rpb_pkg::hex_digit(i_req.data_byte[7:4]);
                o_job.chars[1] = rpb_pkg::hex_digit(i_req.data_byte[3:0]);
            end
            rpb_pkg::FUNC_SUM: begin
                o_job.kind = rpb_pkg::KIND_SUM;
            end
            default: begin
                o_job.kind = rpb_pkg::KIND_NONE;
            end
        endcase
    end

    assign i_req.ready = i_job_ready;

endmodule

`default_nettype wire

// ----- sv/rpb_fifo.sv -----
`default_nettype none

// Small job queue between decode and execution.
module rpb_fifo #(
    parameter int DEPTH = rpb_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire rpb_pkg::t_job i_push_job,
    output logic               o_pop_valid,
    input  wire logic          i_pop,
    output rpb_pkg::t_job      o_pop_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rpb_pkg::t_job      r_mem [DEPTH];
    logic [AW-1:0]      r_wr, n_wr;
    logic [AW-1:0]      r_rd, n_rd;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               push, pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_job    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

endmodule

`default_nettype wire

// ----- sv/rpb_back.sv -----
`default_nettype none

// Executes jobs: length checks, checksum state, one result per ready cycle.
module rpb_back #(
    parameter int MAX_LIMIT = rpb_pkg::MAX_LIMIT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    input  wire rpb_pkg::t_job i_job,
    output logic               o_job_pop,
    rpb_rsp_if.source          o_rsp,
    rpb_cfg_if.sink            i_cfg
);

    localparam int LW   = $clog2(MAX_LIMIT + 1);
    localparam int CMPW = ((LW > rpb_pkg::CFG_W) ? LW : rpb_pkg::CFG_W) + 1;
    localparam int RST_LIM = (rpb_pkg::LIMIT_RESET > MAX_LIMIT) ? MAX_LIMIT
                                                                : rpb_pkg::LIMIT_RESET;
    localparam int CW = rpb_pkg::CHAR_W;

    // message state
    logic [LW-1:0]                 r_eff, n_eff;
    logic [LW-1:0]                 r_count, n_count;
    logic [CW-1:0]                 r_sum, n_sum;
    logic                          r_marker, n_marker;
    logic [rpb_pkg::STATUS_W-1:0]  r_err, n_err;

    // job in progress
    logic                          r_busy, n_busy;
    logic [2:0]                    r_left, n_left;
    logic                          r_chk, n_chk;
    logic [6:0][CW-1:0]            r_pend, n_pend;

    // output register
    logic                          r_ov, n_ov;
    logic [CW-1:0]                 r_char, n_char;
    logic                          r_cv, n_cv;
    logic                          r_last, n_last;
    logic [rpb_pkg::STATUS_W-1:0]  r_st, n_st;

    logic                          out_free;
    logic                          fail1, fail3, fail8;
    logic [CMPW-1:0]               cfg_ext;

    assign out_free  = !r_ov || o_rsp.ready;
    assign o_job_pop = out_free && !r_busy && i_job_valid;

    // room for n more characters plus terminator
    assign fail1 = ({1'b0, r_count} + (LW+1)'(2)) > {1'b0, r_eff};
    assign fail3 = ({1'b0, r_count} + (LW+1)'(4)) > {1'b0, r_eff};
    assign fail8 = ({1'b0, r_count} + (LW+1)'(9)) > {1'b0, r_eff};

    assign cfg_ext     = CMPW'(i_cfg.data);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        logic          emit;
        logic          is_char;
        logic [CW-1:0] ch;
        logic          last;
        logic [rpb_pkg::STATUS_W-1:0] st;

        emit    = 1'b0;
        is_char = 1'b0;
        ch      = '0;
        last    = 1'b1;
        st      = rpb_pkg::ST_OK;

        n_eff    = r_eff;
        n_count  = r_count;
        n_sum    = r_sum;
        n_marker = r_marker;
        n_err    = r_err;
        n_busy   = r_busy;
        n_left   = r_left;
        n_chk    = r_chk;
        n_pend   = r_pend;
        n_ov     = r_ov;
        n_char   = r_char;
        n_cv     = r_cv;
        n_last   = r_last;
        n_st     = r_st;

        if (i_cfg.valid) begin
            n_eff = (cfg_ext > CMPW'(MAX_LIMIT)) ? LW'(MAX_LIMIT) : LW'(i_cfg.data);
        end

        if (out_free) begin
            if (r_busy) begin
                emit = 1'b1;
                if (r_chk && fail1) begin
                    // low hex digit no longer fits
                    n_err  = rpb_pkg::ST_OVERFLOW;
                    st     = rpb_pkg::ST_OVERFLOW;
                    n_busy = 1'b0;
                end else begin
                    is_char = 1'b1;
                    ch      = r_pend[0];
                    last    = (r_left == 3'd1);
                    n_pend  = {{CW{1'b0}}, r_pend[6:1]};
                    n_left  = r_left - 3'd1;
                    n_busy  = (r_left != 3'd1);
                end
                n_chk = 1'b0;
            end else if (i_job_valid) begin
                emit = 1'b1;
                if (i_job.kind == rpb_pkg::KIND_START) begin
                    n_count  = '0;
                    n_sum    = '0;
                    n_marker = 1'b0;
                    n_err    = rpb_pkg::ST_OK;
                end else if (r_err != rpb_pkg::ST_OK) begin
                    st = r_err;
                end else begin
                    case (i_job.kind)
                        rpb_pkg::KIND_RAW: begin
                            if (fail1) begin
                                n_err = rpb_pkg::ST_OVERFLOW;
                                st    = rpb_pkg::ST_OVERFLOW;
                            end else begin
                                is_char = 1'b1;
                                ch      = i_job.chars[0];
                            end
                        end
                        rpb_pkg::KIND_WORD: begin
                            if (fail8) begin
                                n_err = rpb_pkg::ST_OVERFLOW;
                                st    = rpb_pkg::ST_OVERFLOW;
                            end else begin
                                is_char = 1'b1;
                                ch      = i_job.chars[0];
                                last    = 1'b0;
                                n_pend  = i_job.chars[7:1];
                                n_left  = 3'd7;
                                n_busy  = 1'b1;
                            end
                        end
                        rpb_pkg::KIND_HEX: begin
                            if (fail1) begin
                                n_err = rpb_pkg::ST_OVERFLOW;
                                st    = rpb_pkg::ST_OVERFLOW;
                            end else begin
                                is_char   = 1'b1;
                                ch        = i_job.chars[0];
                                last      = 1'b0;
                                n_pend    = '0;
                                n_pend[0] = i_job.chars[1];
                                n_left    = 3'd1;
                                n_busy    = 1'b1;
                                n_chk     = 1'b1;
                            end
                        end
                        rpb_pkg::KIND_SUM: begin
                            if (!r_marker) begin
                                n_err = rpb_pkg::ST_NO_MARKER;
                                st    = rpb_pkg::ST_NO_MARKER;
                            end else if (fail3) begin
                                n_err = rpb_pkg::ST_OVERFLOW;
                                st    = rpb_pkg::ST_OVERFLOW;
                            end else begin
                                // digits of the sum as it stands before '#'
                                is_char   = 1'b1;
                                ch        = rpb_pkg::CHAR_HASH;
                                last      = 1'b0;
                                n_pend    = '0;
                                n_pend[0] = rpb_pkg::hex_digit(r_sum[7:4]);
                                n_pend[1] = rpb_pkg::hex_digit(r_sum[3:0]);
                                n_left    = 3'd2;
                                n_busy    = 1'b1;
                            end
                        end
                        default: begin
                            st = r_err;
                        end
                    endcase
                end
            end

            if (is_char) begin
                n_count = r_count + 1'b1;
                if (r_marker) begin
                    n_sum = r_sum + ch;
                end else if (ch == rpb_pkg::CHAR_DOLLAR) begin
                    n_marker = 1'b1;
                end
            end

            n_ov   = emit;
            n_char = is_char ? ch : '0;
            n_cv   = is_char;
            n_last = last;
            n_st   = is_char ? rpb_pkg::ST_OK : st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff    <= LW'(RST_LIM);
            r_count  <= '0;
            r_sum    <= '0;
            r_marker <= 1'b0;
            r_err    <= rpb_pkg::ST_OK;
            r_busy   <= 1'b0;
            r_left   <= '0;
            r_chk    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_eff    <= n_eff;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_marker <= n_marker;
            r_err    <= n_err;
            r_busy   <= n_busy;
            r_left   <= n_left;
            r_chk    <= n_chk;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_char <= n_char;
        r_cv   <= n_cv;
        r_last <= n_last;
        r_st   <= n_st;
    end

    assign o_rsp.valid      = r_ov;
    assign o_rsp.out_char   = r_char;
    assign o_rsp.char_valid = r_cv;
    assign o_rsp.run_last   = r_last;
    assign o_rsp.status     = r_st;

endmodule

`default_nettype wire

// ----- sv/rsp_packet_builder_core.sv -----
`default_nettype none

// Remote-debug packet builder. Each request starts a message, appends a raw
// character, appends a 32-bit value as eight lowercase hex digits (msb first
// or byte-swapped), appends a byte as two hex digits, or finishes the message
// with or without '#' and a two-digit mod-256 sum of everything after the
// first '$'. Every character leaves as one response; requests that emit no
// character give one response carrying the status, and run_last marks the
// final response of each request. Overflow of the configured length limit
// (terminator counted) and a checksum finish without '$' are sticky errors,
// cleared only by a start request. Requests enter a four-entry job queue at one per
// cycle while it has room; execution gives one response per cycle while the
// receiver is ready, with 1 to 8 responses per request, so single-response requests
// stream at one per cycle if nothing stalls. The first response passes the job
// queue and output register. The limit register takes effect on the next request;
// the user must write it only while the block is idle (not enforced by the block).
// Values above MAX_LIMIT act as MAX_LIMIT. No clearing pass is needed after reset.
module rsp_packet_builder_core #(
    parameter int MAX_LIMIT = rpb_pkg::MAX_LIMIT_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rpb_req_if.sink     i_req,
    rpb_rsp_if.source   o_rsp,
    rpb_cfg_if.sink     i_cfg
);

    // decoded request into the queue
    rpb_pkg::t_job  front_job;
    logic           front_valid;
    logic           front_ready;

    // queue head to execution
    rpb_pkg::t_job  head_job;
    logic           head_valid;
    logic           head_pop;

    // classify: value digits are built here, state checks happen later
    rpb_front u_front (
        .i_req       (i_req),
        .o_job       (front_job),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready)
    );

    // decouples acceptance from multi-cycle character output
    rpb_fifo #(
        .DEPTH (rpb_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_job   (front_job),
        .o_pop_valid  (head_valid),
        .i_pop        (head_pop),
        .o_pop_job    (head_job)
    );

    // length checks, checksum, sticky error, registered response
    rpb_back #(
        .MAX_LIMIT (MAX_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (head_valid),
        .i_job       (head_job),
        .o_job_pop   (head_pop),
        .o_rsp       (o_rsp),
        .i_cfg       (i_cfg)
    );

endmodule

`default_nettype wire

// ----- tb/rsp_packet_builder_core_tb.sv -----
`timescale 1ns / 100ps

module rsp_packet_builder_core_tb;
    import rpb_pkg::*;

    // the one func code the block leaves unused
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

    localparam int PKT_MAX      = MAX_LIMIT_DEF;
    localparam int DRAIN_CYCLES = 8;     // settling margin once no responses are owed
    localparam int LONG_HOLD    = 120;   // receiver hold-off, long enough to fill the job queue
    localparam int PHASE_ITEMS  = 48;
    localparam int MAX_REPORTS  = 40;

    // one expected response
    typedef struct packed {
        logic [CHAR_W-1:0]   ch;
        logic                cv;
        logic                last;
        logic [STATUS_W-1:0] st;
    } t_rsp;

    // one row of the directed table; typed rows carry their expected characters
    typedef struct {
        bit                  is_cfg;
        logic [CFG_W-1:0]    lim;
        logic [FUNC_W-1:0]   fn;
        logic [CHAR_W-1:0]   db;
        logic [WORD_W-1:0]   vw;
        bit                  typed;
        string               txt;
        bit                  tail;
        logic [STATUS_W-1:0] st;
    } t_row;

    logic clk;
    logic rst_n;

    rpb_req_if req_if();
    rpb_rsp_if rsp_if();
    rpb_cfg_if cfg_if();

    rsp_packet_builder_core u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // builder state as seen from outside
    int unsigned         msg_len;
    logic [7:0]          chk_sum;
    bit                  seen_dollar;
    logic [STATUS_W-1:0] err_state;
    logic [CFG_W-1:0]    lim_reg;

    t_rsp built_rsp[$];    // responses of the request just taken
    t_rsp due_rsp_q[$];    // responses still owed by the block
    t_row dir_tab[$];

    int  n_items, n_useful, n_rsp, n_errors, n_reports;
    int  n_sums, n_ovf, n_nomark, n_limits;
    int  gap_pct, stall_pct;
    bit  hold_rsp;

    // ---------------------------------------------------------------------
    // clock
    // ---------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // builder behaviour
    // ---------------------------------------------------------------------
    function automatic logic [7:0] nib_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + n : 8'h57 + n;    // 'a' - 10 = 8'h57
    endfunction

    // room for n more characters plus the terminator, else overflow
    function automatic bit fits(input int unsigned n);
        int unsigned eff;
        eff = (lim_reg > PKT_MAX) ? PKT_MAX : lim_reg;
        if (msg_len + n + 1 > eff) begin
            err_state = ST_OVERFLOW;
            n_ovf++;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // first '$' opens the checksum span and is not summed itself
    function automatic void add_char(input logic [7:0] ch);
        if (seen_dollar)
            chk_sum = chk_sum + ch;
        else if (ch == CHAR_DOLLAR)
            seen_dollar = 1'b1;
        msg_len++;
        built_rsp.push_back('{ch, 1'b1, 1'b0, ST_OK});
    endfunction

    // works out the responses of one request into built_rsp;
    // returns 1 when the request did anything beyond being ignored
    function automatic bit run_builder(input logic [FUNC_W-1:0] fn, input logic [7:0] db,
                                       input logic [31:0] vw);
        logic [7:0]          s;
        logic [STATUS_W-1:0] err_in;
        err_in = err_state;
        built_rsp.delete();
        if (fn == FUNC_START) begin
            msg_len     = 0;
            chk_sum     = 8'h00;
            seen_dollar = 1'b0;
            err_state   = ST_OK;
        end else if (err_state == ST_OK) begin
            case (fn)
                FUNC_RAW: begin
                    if (fits(1)) add_char(db);
                end
                FUNC_WORD_MSB: begin
                    if (fits(8))
                        for (int i = 7; i >= 0; i--) add_char(nib_char(vw[4*i +: 4]));
                end
                FUNC_WORD_SWP: begin
                    if (fits(8))
                        for (int i = 0; i < 4; i++) begin
                            add_char(nib_char(vw[8*i+4 +: 4]));
                            add_char(nib_char(vw[8*i +: 4]));
                        end
                end
                FUNC_HEX: begin
                    // digits checked one at a time: the high one may go out alone
                    if (fits(1)) begin
                        add_char(nib_char(db[7:4]));
                        if (fits(1)) add_char(nib_char(db[3:0]));
                    end
                end
                FUNC_SUM: begin
                    if (!seen_dollar) begin
                        err_state = ST_NO_MARKER;
                        n_nomark++;
                    end else if (fits(3)) begin
                        s = chk_sum;
                        add_char(CHAR_HASH);
                        add_char(nib_char(s[7:4]));
                        add_char(nib_char(s[3:0]));
                        n_sums++;
                    end
                end
                default: ;
            endcase
        end
        if (built_rsp.size() == 0 || err_state != ST_OK)
            built_rsp.push_back('{8'h00, 1'b0, 1'b0, err_state});
        built_rsp[built_rsp.size()-1].last = 1'b1;
        return (fn == FUNC_START) || (built_rsp[0].cv == 1'b1) || (err_in != err_state);
    endfunction

    // ---------------------------------------------------------------------
    // request and limit drivers
    // ---------------------------------------------------------------------
    task automatic send_req(input t_row rw);
        @(negedge clk);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.func       <= rw.fn;
        req_if.data_byte  <= rw.db;
        req_if.value_word <= rw.vw;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        n_items++;
        if (run_builder(rw.fn, rw.db, rw.vw)) n_useful++;
        if (rw.typed) begin
            // table row carries its own answer; the builder state has still moved on
            built_rsp.delete();
            for (int k = 0; k < rw.txt.len(); k++)
                built_rsp.push_back('{rw.txt[k], 1'b1, 1'b0, ST_OK});
            if (rw.tail) built_rsp.push_back('{8'h00, 1'b0, 1'b0, rw.st});
            built_rsp[built_rsp.size()-1].last = 1'b1;
        end
        foreach (built_rsp[k]) due_rsp_q.push_back(built_rsp[k]);
    endtask

    task automatic send_plain(input logic [FUNC_W-1:0] fn, input logic [7:0] db,
                              input logic [31:0] vw);
        t_row rw;
        rw.is_cfg = 1'b0;
        rw.lim    = '0;
        rw.fn     = fn;
        rw.db     = db;
        rw.vw     = vw;
        rw.typed  = 1'b0;
        rw.txt    = "";
        rw.tail   = 1'b0;
        rw.st     = ST_OK;
        send_req(rw);
    endtask

    // limit only changes once the block has gone quiet
    task automatic write_limit(input logic [CFG_W-1:0] v);
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (due_rsp_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        lim_reg = v;
        n_limits++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic void tab_row(input bit typed, input logic [FUNC_W-1:0] fn,
                                    input logic [7:0] db, input logic [31:0] vw,
                                    input string txt, input bit tail,
                                    input logic [STATUS_W-1:0] st);
        t_row rw;
        rw.is_cfg = 1'b0;
        rw.lim    = '0;
        rw.fn     = fn;
        rw.db     = db;
        rw.vw     = vw;
        rw.typed  = typed;
        rw.txt    = txt;
        rw.tail   = tail;
        rw.st     = st;
        dir_tab.push_back(rw);
    endfunction

    function automatic void tab_cfg(input logic [CFG_W-1:0] v);
        t_row rw;
        rw.is_cfg = 1'b1;
        rw.lim    = v;
        rw.fn     = FUNC_FINISH;
        rw.db     = '0;
        rw.vw     = '0;
        rw.typed  = 1'b0;
        rw.txt    = "";
        rw.tail   = 1'b0;
        rw.st     = ST_OK;
        dir_tab.push_back(rw);
    endfunction

    function automatic logic [7:0] rand_char();
        return ($urandom_range(0, 9) == 0) ? CHAR_DOLLAR : 8'($urandom_range(0, 255));
    endfunction

    // well-formed packet: start, optional preamble, '$', body, finish
    task automatic send_message();
        send_plain(FUNC_START, rand_char(), $urandom);
        repeat ($urandom_range(0, 2)) send_plain(FUNC_RAW, rand_char(), $urandom);
        send_plain(FUNC_RAW, CHAR_DOLLAR, $urandom);
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
                0:       send_plain(FUNC_RAW, rand_char(), $urandom);
                1:       send_plain(FUNC_WORD_MSB, rand_char(), $urandom);
                2:       send_plain(FUNC_WORD_SWP, rand_char(), $urandom);
                default: send_plain(FUNC_HEX, 8'($urandom_range(0, 255)), $urandom);
            endcase
        end
        if ($urandom_range(0, 3) != 0)
            send_plain(FUNC_SUM, rand_char(), $urandom);
        else
            send_plain(FUNC_FINISH, rand_char(), $urandom);
        // a second checksum also covers the first one
        if ($urandom_range(0, 4) == 0)
            send_plain(FUNC_SUM, rand_char(), $urandom);
    endtask

    // ---------------------------------------------------------------------
    // response side: random stalls, one long hold-off on request
    // ---------------------------------------------------------------------
    initial begin
        int stall;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_rsp) begin
                hold_rsp = 1'b0;
                stall = LONG_HOLD;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                stall = $urandom_range(1, 18);
            end else begin
                stall = 0;
            end
            if (stall != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
        end
    end

    function automatic void report_miss(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        n_errors++;
        if (n_reports < MAX_REPORTS) begin
            n_reports++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    // every response against the oldest one owed
    always @(posedge clk) begin
        t_rsp want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            n_rsp++;
            if (due_rsp_q.size() == 0) begin
                n_errors++;
                if (n_reports < MAX_REPORTS) begin
                    n_reports++;
                    $display("%0t: response with none expected, expected nothing, got char %0h",
                             $time, rsp_if.out_char);
                end
            end else begin
                want = due_rsp_q.pop_front();
                if (rsp_if.out_char !== want.ch)
                    report_miss("out_char", want.ch, rsp_if.out_char);
                if (rsp_if.char_valid !== want.cv)
                    report_miss("char_valid", 8'(want.cv), 8'(rsp_if.char_valid));
                if (rsp_if.run_last !== want.last)
                    report_miss("run_last", 8'(want.last), 8'(rsp_if.run_last));
                if (rsp_if.status !== want.st)
                    report_miss("status", 8'(want.st), 8'(rsp_if.status));
            end
        end
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------
    initial begin
        int unsigned ph_lim [8] = '{40, 1, 12, 4096, 20, 8191, 0, 64};
        int          ph_gap [8] = '{0, 20, 10, 30, 0, 15, 25, 0};
        int          ph_stl [8] = '{0, 5, 20, 10, 3, 0, 15, 0};
        int unsigned lim;
        int          goal;

        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.func       = FUNC_START;
        req_if.data_byte  = '0;
        req_if.value_word = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.data       = '0;
        hold_rsp          = 1'b0;
        gap_pct           = 15;
        stall_pct         = 10;

        msg_len     = 0;
        chk_sum     = 8'h00;
        seen_dollar = 1'b0;
        err_state   = ST_OK;
        lim_reg     = CFG_W'(LIMIT_RESET);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset limit first
        tab_row(1, FUNC_FINISH, 8'h00, 32'h0, "", 1, ST_OK);
        tab_row(1, FUNC_SUM, 8'h00, 32'h0, "", 1, ST_NO_MARKER);      // checksum with no '$'
        tab_row(1, FUNC_RAW, "A", 32'h0, "", 1, ST_NO_MARKER);        // sticky
        tab_row(1, FUNC_START, 8'hff, 32'hffff_ffff, "", 1, ST_OK);
        tab_row(0, FUNC_RAW, 8'h00, 32'h0, "", 0, ST_OK);             // zero byte, plain char
        tab_row(1, FUNC_RAW, CHAR_DOLLAR, 32'h0, "$", 0, ST_OK);
        tab_row(1, FUNC_WORD_MSB, 8'h00, 32'h0000_0000, "00000000", 0, ST_OK);
        tab_row(1, FUNC_WORD_MSB, 8'h00, 32'hffff_ffff, "ffffffff", 0, ST_OK);
        tab_row(1, FUNC_WORD_SWP, 8'h00, 32'h1234_5678, "78563412", 0, ST_OK);
        tab_row(1, FUNC_HEX, 8'h00, 32'h0, "00", 0, ST_OK);
        tab_row(1, FUNC_HEX, 8'hff, 32'h0, "ff", 0, ST_OK);
        tab_row(0, FUNC_RAW, CHAR_DOLLAR, 32'h0, "", 0, ST_OK);       // second '$' is summed
        tab_row(0, FUNC_SUM, 8'h00, 32'h0, "", 0, ST_OK);
        tab_row(0, FUNC_SUM, 8'h00, 32'h0, "", 0, ST_OK);             // sums the first checksum too
        tab_row(1, FUNC_UNUSED, 8'h5a, 32'hdead_beef, "", 1, ST_OK);
        // limit 11: hex byte splits across the overflow
        tab_cfg(13'd11);
        tab_row(1, FUNC_START, 8'h00, 32'h0, "", 1, ST_OK);
        tab_row(1, FUNC_RAW, CHAR_DOLLAR, 32'h0, "$", 0, ST_OK);
        tab_row(1, FUNC_WORD_MSB, 8'h00, 32'hdead_beef, "deadbeef", 0, ST_OK);
        tab_row(1, FUNC_HEX, 8'h3c, 32'h0, "3", 1, ST_OVERFLOW);
        tab_row(1, FUNC_RAW, "z", 32'h0, "", 1, ST_OVERFLOW);
        tab_row(1, FUNC_START, 8'h00, 32'h0, "", 1, ST_OK);
        tab_row(1, FUNC_RAW, CHAR_DOLLAR, 32'h0, "$", 0, ST_OK);
        tab_row(0, FUNC_SUM, 8'h00, 32'h0, "", 0, ST_OK);
        tab_row(1, FUNC_WORD_SWP, 8'h00, 32'h8765_4321, "", 1, ST_OVERFLOW);  // whole word refused
        // smallest limit: only the terminator fits
        tab_cfg(13'd1);
        tab_row(1, FUNC_START, 8'h00, 32'h0, "", 1, ST_OK);
        tab_row(1, FUNC_RAW, "x", 32'h0, "", 1, ST_OVERFLOW);
        tab_row(1, FUNC_START, 8'h00, 32'h0, "", 1, ST_OK);
        tab_row(1, FUNC_SUM, 8'h00, 32'h0, "", 1, ST_NO_MARKER);

        foreach (dir_tab[r]) begin
            if (dir_tab[r].is_cfg)
                write_limit(dir_tab[r].lim);
            else
                send_req(dir_tab[r]);
        end

        // random phases, each under its own limit and idling mix; the last is calm
        for (int ph = 0; ph < 8; ph++) begin
            lim       = (ph == 6) ? $urandom_range(1, PKT_MAX) : ph_lim[ph];
            gap_pct   = ph_gap[ph];
            stall_pct = ph_stl[ph];
            write_limit(CFG_W'(lim));
            if (ph == 0) hold_rsp = 1'b1;    // sender keeps going, job queue backs up
            goal = n_items + PHASE_ITEMS;
            while (n_items < goal) begin
                if ($urandom_range(0, 4) != 0)
                    send_message();
                else
                    repeat ($urandom_range(1, 4))
                        send_plain(FUNC_W'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                   $urandom);
            end
        end

        @(negedge clk);
        req_if.valid <= 1'b0;
        while (due_rsp_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d moved the message on) under %0d limit settings.",
                 n_items, n_useful, n_limits);
        $display("%0d responses checked; checksums %0d, overflows %0d, missing-marker %0d.",
                 n_rsp, n_sums, n_ovf, n_nomark);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
